### rtl/dfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dfd_pkg;
  localparam int MANT_DIGITS_DEF = 30;
  localparam int EXP_LIMIT_DEF = 99999;
  localparam int EXP_W = 18;
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXP_OVF = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_ALIGN,
    S_DIV,
    S_ROUND,
    S_PACK,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

### rtl/decimal_float_divider.sv
// Sequence (N = MANT_DIGITS): normalize both mantissas, align, develop the N+1 quotient
// digits by repeated BCD subtraction, round over the N quotient digits, then pack; a zero
// operand goes from normalize straight to done.
// One request at a time: s_tready is high only in idle, and the single BCD subtract-compare unit is shared;
// s_tready returns in the cycle after the result is taken.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module decimal_float_divider
  import dfd_pkg::*;
#(
  parameter int MANT_DIGITS = MANT_DIGITS_DEF,
  parameter int EXP_LIMIT = EXP_LIMIT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // dividend_sign, dividend_high, dividend_low, dividend_exp, divisor_sign,
  // divisor_high, divisor_low, divisor_exp; then zero fill
  input  wire logic [279:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // quotient_sign, quotient_high, quotient_low, quotient_exp, status; then zero fill
  output logic [143:0]      m_tdata
);
  localparam int MW = 4 * MANT_DIGITS;
  localparam int WW = MW + 4;
  localparam int CW = $clog2(MANT_DIGITS + 2);
  localparam int XW = EXP_W + 2;
  localparam logic signed [XW-1:0] EXP_HI = XW'(EXP_LIMIT);
  localparam logic signed [XW-1:0] EXP_LO = -EXP_HI;
  localparam logic [CW-1:0] LAST_DIG = CW'(MANT_DIGITS);
  localparam logic [CW-1:0] LAST_RND = CW'(MANT_DIGITS - 1);

  state_t state, state_next;

  logic [WW-1:0] rem, dvs;
  logic [MW-1:0] q;
  logic [MW-1:0] m1, m2;
  logic signed [XW-1:0] e1, e2, ex;
  logic sgn;
  logic [CW-1:0] cnt;
  logic [3:0] dig;
  logic rnd_carry;
  logic [143:0] out;
  logic [MW-1:0] in1, in2;

  // One BCD subtractor, shared by the divide steps.
  logic [WW-1:0] diff;
  logic ge;
  always_comb begin
    logic bor;
    logic signed [5:0] v;
    bor = 1'b0;
    for (int i = 0; i < WW / 4; i++) begin
      v = $signed({2'b00, rem[4*i +: 4]}) - $signed({2'b00, dvs[4*i +: 4]}) -
          $signed({5'd0, bor});
      bor = v < 0;
      if (bor) v = v + 6'sd10;
      diff[4*i +: 4] = v[3:0];
    end
    ge = !bor;
  end

  function automatic logic [MW-1:0] unpack(input logic [59:0] hi, input logic [59:0] lo);
    logic [119:0] all;
    logic [MW-1:0] r;
    all = {hi, lo};
    for (int i = 0; i < MANT_DIGITS; i++)
      r[MW-4-4*i +: 4] = (all[116-4*i +: 4] > 4'd9) ? 4'd9 : all[116-4*i +: 4];
    return r;
  endfunction

  assign in1 = unpack(s_tdata[60:1], s_tdata[120:61]);
  assign in2 = unpack(s_tdata[199:140], s_tdata[259:200]);

  logic top1z, top2z, all1z, all2z;
  assign top1z = m1[MW-1 -: 4] == 4'd0;
  assign top2z = m2[MW-1 -: 4] == 4'd0;
  assign all1z = m1 == '0;
  assign all2z = m2 == '0;

  logic [3:0] low_dig, low_next;
  assign low_dig = q[3:0];
  assign low_next = !rnd_carry ? low_dig : (low_dig == 4'd9) ? 4'd0 : low_dig + 4'd1;

  logic [119:0] q_fin;
  logic signed [XW-1:0] ex_fin;
  logic ovf;
  always_comb begin
    q_fin = '0;
    if (rnd_carry) q_fin[119 -: 4] = 4'd1;
    else q_fin[119 -: MW] = q;
  end
  assign ex_fin = ex + (rnd_carry ? XW'(1) : XW'(0));
  assign ovf = ex_fin > EXP_HI || ex_fin < EXP_LO;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_NORM;
      S_NORM: begin
        if (all2z || all1z) state_next = S_DONE;
        else if (!top1z && !top2z) state_next = S_ALIGN;
      end
      S_ALIGN: state_next = S_DIV;
      S_DIV:   if ((!ge || dig == 4'd9) && cnt == LAST_DIG) state_next = S_ROUND;
      S_ROUND: if (cnt == LAST_RND) state_next = S_PACK;
      S_PACK:  state_next = S_DONE;
      S_DONE:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = state == S_IDLE;
    m_tvalid = state == S_DONE;
    m_tdata = out;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        m1 <= in1;
        m2 <= in2;
        e1 <= XW'($signed(s_tdata[138:121]));
        e2 <= XW'($signed(s_tdata[277:260]));
        sgn <= s_tdata[0] ^ s_tdata[139];
      end
      S_NORM: begin
        if (all2z) begin
          out <= {3'd0, ST_DIV_ZERO, 139'd0};
        end else if (all1z) begin
          out <= {143'd0, sgn};
        end else begin
          if (top1z) begin
            m1 <= m1 << 4;
            e1 <= e1 - XW'(1);
          end
          if (top2z) begin
            m2 <= m2 << 4;
            e2 <= e2 - XW'(1);
          end
        end
      end
      S_ALIGN: begin
        dvs <= {4'd0, m2};
        cnt <= '0;
        dig <= '0;
        q <= '0;
        rnd_carry <= 1'b0;
        if (m1 >= m2) begin
          rem <= {4'd0, m1};
          ex <= e1 - e2 + XW'(1);
        end else begin
          rem <= {m1, 4'd0};
          ex <= e1 - e2;
        end
      end
      S_DIV: begin
        if (ge && dig != 4'd9) begin
          rem <= diff;
          dig <= dig + 4'd1;
        end else begin
          rem <= {rem[WW-5:0], 4'd0};
          dig <= '0;
          if (cnt == LAST_DIG) begin
            rnd_carry <= dig > 4'd4;
            cnt <= '0;
          end else begin
            q <= {q[MW-5:0], dig};
            cnt <= cnt + CW'(1);
          end
        end
      end
      S_ROUND: begin
        q <= {low_next, q[MW-1:4]};
        rnd_carry <= rnd_carry && low_dig == 4'd9;
        cnt <= cnt + CW'(1);
      end
      S_PACK: begin
        if (ovf) out <= {3'd0, ST_EXP_OVF, 139'd0};
        else out <= {3'd0, ST_OK, ex_fin[EXP_W-1:0], q_fin[59:0], q_fin[119:60], sgn};
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### verif/tb_decimal_float_divider.sv
`timescale 1ns / 1ps
module tb_decimal_float_divider;
  import dfd_pkg::*;

  localparam int NDIG = MANT_DIGITS_DEF;
  localparam int ELIM = EXP_LIMIT_DEF;
  localparam int N_RANDOM = 530;
  localparam int STALL_LIMIT = 20000;
  localparam int QUIET_FROM = 30000;
  localparam int QUIET_TO = 90000;

  typedef struct packed {
    logic [EXP_W-1:0] dvs_exp;
    logic [59:0] dvs_low;
    logic [59:0] dvs_high;
    logic dvs_sign;
    logic [EXP_W-1:0] dvd_exp;
    logic [59:0] dvd_low;
    logic [59:0] dvd_high;
    logic dvd_sign;
  } div_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EXP_W-1:0] exp;
    logic [59:0] low;
    logic [59:0] high;
    logic sign;
  } quot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [279:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [143:0] m_tdata;

  div_req_t pending_reqs[$];
  quot_t expected_quots[$];
  div_req_t cur_req;
  int unsigned cycle_cnt = 0;
  int unsigned stall_cnt = 0;
  int errors = 0;
  int n_checked = 0;
  int n_divzero = 0;
  int n_ovf = 0;
  logic [279:0] req_bits;

  decimal_float_divider u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void get_digits(input logic [59:0] hi, input logic [59:0] lo,
                                     output int d[NDIG]);
    int nib;
    for (int i = 0; i < NDIG; i++) begin
      nib = (i < 15) ? int'(hi[(14 - i) * 4 +: 4]) : int'(lo[(29 - i) * 4 +: 4]);
      d[i] = (nib > 9) ? 9 : nib;
    end
  endfunction

  function automatic bit strip_zeros(inout int d[NDIG], inout int e);
    int z;
    z = 0;
    while (z < NDIG && d[z] == 0) z++;
    if (z == NDIG) return 1'b0;
    for (int i = 0; i < NDIG; i++) d[i] = (i + z < NDIG) ? d[i + z] : 0;
    e -= z;
    return 1'b1;
  endfunction

  function automatic quot_t divide_decimal(div_req_t r);
    int a[NDIG], b[NDIG], rem[NDIG + 1], dv[NDIG + 1], q[NDIG + 1];
    int ea, eb, ex, c, cmpv, v, borrow, carry;
    bit nza, nzb;
    quot_t res;
    res = '0;
    ea = int'(signed'(r.dvd_exp));
    eb = int'(signed'(r.dvs_exp));
    get_digits(r.dvd_high, r.dvd_low, a);
    get_digits(r.dvs_high, r.dvs_low, b);
    nza = strip_zeros(a, ea);
    nzb = strip_zeros(b, eb);
    if (!nzb) begin
      res.status = ST_DIV_ZERO;
      return res;
    end
    if (!nza) begin
      res.sign = r.dvd_sign ^ r.dvs_sign;
      return res;
    end
    rem[0] = 0;
    dv[0] = 0;
    for (int i = 0; i < NDIG; i++) begin
      rem[i + 1] = a[i];
      dv[i + 1] = b[i];
    end
    ex = ea - eb;
    cmpv = 0;
    for (int i = 0; i <= NDIG && cmpv == 0; i++)
      if (rem[i] != dv[i]) cmpv = (rem[i] > dv[i]) ? 1 : -1;
    if (cmpv >= 0) ex += 1;
    else begin
      for (int i = 0; i < NDIG; i++) rem[i] = rem[i + 1];
      rem[NDIG] = 0;
    end
    for (int k = 0; k <= NDIG; k++) begin
      c = 0;
      while (c < 9) begin
        cmpv = 0;
        for (int i = 0; i <= NDIG && cmpv == 0; i++)
          if (rem[i] != dv[i]) cmpv = (rem[i] > dv[i]) ? 1 : -1;
        if (cmpv < 0) break;
        borrow = 0;
        for (int i = NDIG; i >= 0; i--) begin
          v = rem[i] - dv[i] - borrow;
          borrow = (v < 0);
          rem[i] = (v < 0) ? v + 10 : v;
        end
        c++;
      end
      q[k] = c;
      for (int i = 0; i < NDIG; i++) rem[i] = rem[i + 1];
      rem[NDIG] = 0;
    end
    if (q[NDIG] > 4) begin
      carry = 1;
      for (int i = NDIG - 1; i >= 0 && carry != 0; i--) begin
        if (q[i] == 9) q[i] = 0;
        else begin
          q[i] = q[i] + 1;
          carry = 0;
        end
      end
      if (carry != 0) begin
        q[0] = 1;
        ex += 1;
      end
    end
    if (ex > ELIM || ex < -ELIM) begin
      res.status = ST_EXP_OVF;
      return res;
    end
    res.sign = r.dvd_sign ^ r.dvs_sign;
    for (int i = 0; i < 15; i++) begin
      res.high[(14 - i) * 4 +: 4] = 4'(q[i]);
      res.low[(14 - i) * 4 +: 4] = 4'(q[i + 15]);
    end
    res.exp = ex[EXP_W-1:0];
    res.status = ST_OK;
    return res;
  endfunction

  // Mantissa of 30 nibbles: mostly proper BCD, sometimes raw nibbles or leading zeros.
  function automatic logic [119:0] rand_mant();
    logic [119:0] m;
    int kind, lead;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 30; i++)
      m[i * 4 +: 4] = (kind == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
    if (kind >= 7) begin
      lead = $urandom_range(1, 30);
      for (int i = 0; i < lead; i++) m[(29 - i) * 4 +: 4] = 4'd0;
    end
    return m;
  endfunction

  function automatic logic [EXP_W-1:0] rand_exp();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) return EXP_W'($urandom_range(0, 60) - 30);
    if (kind < 8) return EXP_W'($urandom_range(0, 2 * ELIM) - ELIM);
    if (kind == 8) return EXP_W'(($urandom_range(0, 1) != 0) ? ELIM - $urandom_range(0, 40)
                                                         : -ELIM + $urandom_range(0, 40));
    return EXP_W'($urandom);
  endfunction

  task automatic add_req(logic sa, logic [119:0] ma, logic [EXP_W-1:0] ea,
                         logic sb, logic [119:0] mb, logic [EXP_W-1:0] eb);
    div_req_t r;
    r.dvd_sign = sa;
    r.dvd_high = ma[119:60];
    r.dvd_low = ma[59:0];
    r.dvd_exp = ea;
    r.dvs_sign = sb;
    r.dvs_high = mb[119:60];
    r.dvs_low = mb[59:0];
    r.dvs_exp = eb;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [119:0] fill_digit(logic [3:0] d);
    return {30{d}};
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_quots.push_back(divide_decimal(cur_req));
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && ((cycle_cnt > QUIET_FROM && cycle_cnt < QUIET_TO)
            || $urandom_range(0, 99) >= 17)) begin
          cur_req = pending_reqs.pop_front();
          req_bits = {2'b00, cur_req};
          s_tdata <= req_bits;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    quot_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (cycle_cnt > QUIET_FROM && cycle_cnt < QUIET_TO)
                  || $urandom_range(0, 99) >= 17;
      if (m_tvalid && m_tready) begin
        got = m_tdata[140:0];
        if (expected_quots.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected quotient %h", got);
        end else begin
          want = expected_quots.pop_front();
          n_checked++;
          if (want.status == ST_DIV_ZERO) n_divzero++;
          if (want.status == ST_EXP_OVF) n_ovf++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: quotient %0d: sign %b/%b high %h/%h low %h/%h exp %h/%h st %0d/%0d",
                       n_checked, want.sign, got.sign, want.high, got.high, want.low, got.low,
                       want.exp, got.exp, want.status, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Timeout with %0d requests and %0d quotients outstanding",
                 pending_reqs.size(), expected_quots.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [119:0] one, max_bcd, two, three;
    one = {4'd1, 116'd0};
    two = {4'd2, 116'd0};
    three = {4'd3, 116'd0};
    max_bcd = fill_digit(4'd9);
    add_req(1'b0, one, 18'd0, 1'b0, one, 18'd0);
    add_req(1'b1, max_bcd, 18'd5, 1'b0, max_bcd, 18'd3);
    add_req(1'b0, two, 18'd0, 1'b1, three, 18'd0);
    add_req(1'b1, one, 18'd1, 1'b1, three, -18'sd2);
    add_req(1'b0, one, 18'd0, 1'b0, '0, 18'd0);
    add_req(1'b1, '0, 18'd7, 1'b0, '0, 18'd0);
    add_req(1'b1, '0, 18'd4, 1'b0, two, 18'd9);
    add_req(1'b0, fill_digit(4'hf), 18'h3ffff, 1'b0, fill_digit(4'ha), 18'h20000);
    add_req(1'b0, 120'd1, 18'd0, 1'b0, one, 18'd0);
    add_req(1'b0, one, 18'd0, 1'b0, 120'd1, 18'd0);
    add_req(1'b0, max_bcd, 18'd0, 1'b0, {4'd1, 112'd0, 4'd1}, 18'd0);
    add_req(1'b0, max_bcd, 18'(ELIM), 1'b0, one, 18'd0);
    add_req(1'b0, one, 18'(ELIM), 1'b0, two, 18'd0);
    add_req(1'b0, one, 18'(-ELIM), 1'b0, one, 18'd1);
    add_req(1'b0, two, 18'(-ELIM), 1'b0, one, 18'd0);
    add_req(1'b1, max_bcd, 18'h1ffff, 1'b1, one, 18'h20000);
    add_req(1'b0, 120'h123456789012345678901234567890, 18'd0,
            1'b1, 120'h000000000000000000000000000007, 18'd0);
    add_req(1'b1, 120'hffffffffffffffff0000000000000f, 18'd3,
            1'b0, 120'h0f0f0f0f0f0f0f0f0f0f0f0f0f0f0f, 18'h3fff0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 29) == 0)
        add_req(1'($urandom), rand_mant(), rand_exp(), 1'($urandom), '0, rand_exp());
      else if ($urandom_range(0, 29) == 0)
        add_req(1'($urandom), '0, rand_exp(), 1'($urandom), rand_mant(), rand_exp());
      else
        add_req(1'($urandom), rand_mant(), rand_exp(), 1'($urandom), rand_mant(), rand_exp());
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !s_tvalid && expected_quots.size() == 0);
    repeat (600) @(posedge clk);
    $display("Checked %0d quotients, %0d divisions by zero, %0d exponent overflows.",
             n_checked, n_divzero, n_ovf);
    if (errors == 0 && expected_quots.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### files.f
rtl/dfd_pkg.sv
rtl/decimal_float_divider.sv
verif/tb_decimal_float_divider.sv
